@@ sv/atlb_pkg.sv @@
// ----------------------------------------------------------------------------
// atlb_pkg
// Shared types, widths and codes for the asid tagged translation buffer.
// ----------------------------------------------------------------------------
package atlb_pkg;

  localparam int unsigned DEF_ENTRIES    = 64;
  localparam int unsigned DEF_PAGE_SHIFT = 13;
  localparam int unsigned DEF_TAG_BITS   = 30;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned VA_W      = 43;
  localparam int unsigned ASN_W     = 8;
  localparam int unsigned FRAME_W   = 31;
  localparam int unsigned MODES_W   = 4;
  localparam int unsigned PERM_W    = 2 * MODES_W + 2;
  localparam int unsigned HIT_IDX_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP     = 3'd0,
    KIND_INSERT     = 3'd1,
    KIND_FLUSH_ALL  = 3'd2,
    KIND_FLUSH_NG   = 3'd3,
    KIND_FLUSH_ADDR = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch request, restart scan
    logic scan;    // walk the entries
    logic exec;    // update (insert, flush all and flush non-global)
    logic finish;  // load result registers
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              hit;   // compared entry matches
    logic              last;  // compared entry is the last one
    logic [KIND_W-1:0] kind;  // latched request kind
  } status_t;

endpackage

@@ sv/atlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// atlb_ctrl
// Sequencer: accepts a request, runs an entry scan or an update,
// and raises the result strobe.
// ----------------------------------------------------------------------------
module atlb_ctrl
  import atlb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KIND_W-1:0] kind_i,
  input  status_t           status_i,
  output cmd_t              cmd_o,
  output logic              busy_o,
  output logic              valid_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   scan_kind;
  logic   scan_done;

  assign scan_kind = (kind_i == KIND_LOOKUP) || (kind_i == KIND_FLUSH_ADDR);
  assign scan_done = status_i.last ||
                     (status_i.hit && (status_i.kind == KIND_LOOKUP));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = scan_kind ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.finish = scan_done;
      end
      ST_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
    valid_d = cmd_o.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q;

`ifndef NO_ASSERTIONS
  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q != ST_IDLE))
    else $error("result strobe without a request in flight");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not make the block busy");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> state_q == ST_IDLE && valid_o)
    else $error("update did not finish in one cycle");
`endif

endmodule

@@ sv/atlb_dp.sv @@
// ----------------------------------------------------------------------------
// atlb_dp
// Entry storage, scan counter, tag compare and result registers.
// ----------------------------------------------------------------------------
module atlb_dp
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES    = DEF_ENTRIES,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [VA_W-1:0]      virtual_address_i,
  input  logic [ASN_W-1:0]     asn_i,
  input  logic [FRAME_W-1:0]   new_page_frame_i,
  input  logic                 new_global_i,
  input  logic [MODES_W-1:0]   new_read_modes_i,
  input  logic [MODES_W-1:0]   new_write_modes_i,
  input  logic                 new_fault_on_read_i,
  input  logic                 new_fault_on_write_i,
  output logic                 hit_o,
  output logic [HIT_IDX_W-1:0] hit_index_o,
  output logic [FRAME_W-1:0]   page_frame_o,
  output logic                 global_page_o,
  output logic [MODES_W-1:0]   read_modes_o,
  output logic [MODES_W-1:0]   write_modes_o,
  output logic                 fault_on_read_o,
  output logic                 fault_on_write_o
);

  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FRM_LSB = PERM_W;
  localparam int unsigned ASN_LSB = PERM_W + FRAME_W;
  localparam int unsigned TAG_LSB = PERM_W + FRAME_W + ASN_W;
  localparam int unsigned ENT_W   = TAG_LSB + TAG_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // request registers
  logic [KIND_W-1:0]   kind_q;
  logic [TAG_BITS-1:0] page_q;
  logic [ASN_W-1:0]    asn_q;
  logic [FRAME_W-1:0]  frame_q;
  logic                nglob_q;
  logic [PERM_W-1:0]   perm_q;

  logic [VA_W+TAG_BITS-1:0] va_shift;
  logic [TAG_BITS-1:0]      page_in;

  assign va_shift = {{TAG_BITS{1'b0}}, virtual_address_i} >> PAGE_SHIFT;
  assign page_in  = va_shift[TAG_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      page_q  <= page_in;
      asn_q   <= asn_i;
      frame_q <= new_page_frame_i;
      nglob_q <= new_global_i;
      perm_q  <= {new_fault_on_write_i, new_fault_on_read_i,
                  new_write_modes_i, new_read_modes_i};
    end
  end

  // per-entry valid and global bits
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] glob_q, glob_d;
  logic [IDX_W-1:0]   victim_q, victim_d;

  // scan pipeline: address stage and compare stage
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             issued_q, issued_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] ridx_q;
  logic [ENT_W-1:0] rdata_q;
  logic             rd_en;
  logic             wr_en;

  logic [ENT_W-1:0] mem_q [ENTRIES];

  assign rd_en = cmd_i.scan && !issued_q;
  assign wr_en = cmd_i.exec && (kind_q == KIND_INSERT);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[victim_q] <= {page_q, asn_q, frame_q, perm_q};
    end
    if (rd_en) begin
      rdata_q <= mem_q[cnt_q];
      ridx_q  <= cnt_q;
    end
  end

  logic match;
  assign match = pv_q && valid_q[ridx_q] &&
                 (rdata_q[TAG_LSB +: TAG_BITS] == page_q) &&
                 (glob_q[ridx_q] || (rdata_q[ASN_LSB +: ASN_W] == asn_q));

  assign status_o.hit  = match;
  assign status_o.last = pv_q && (ridx_q == LAST_IDX);
  assign status_o.kind = kind_q;

  always_comb begin
    cnt_d    = cnt_q;
    issued_d = issued_q;
    pv_d     = pv_q;
    if (cmd_i.accept) begin
      cnt_d    = '0;
      issued_d = 1'b0;
      pv_d     = 1'b0;
    end else if (cmd_i.scan) begin
      pv_d = rd_en;
      if (rd_en) begin
        if (cnt_q == LAST_IDX) begin
          issued_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_d  = valid_q;
    glob_d   = glob_q;
    victim_d = victim_q;
    if (cmd_i.exec) begin
      unique case (kind_q)
        KIND_INSERT: begin
          valid_d[victim_q] = 1'b1;
          glob_d[victim_q]  = nglob_q;
          victim_d = (victim_q == LAST_IDX) ? '0 : victim_q + 1'b1;
        end
        KIND_FLUSH_ALL: begin
          valid_d  = '0;
          glob_d   = '0;
          victim_d = '0;
        end
        KIND_FLUSH_NG: begin
          valid_d = valid_q & glob_q;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
    if (cmd_i.scan && (kind_q == KIND_FLUSH_ADDR) && match) begin
      valid_d[ridx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      glob_q   <= '0;
      victim_q <= '0;
      cnt_q    <= '0;
      issued_q <= 1'b0;
      pv_q     <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      glob_q   <= glob_d;
      victim_q <= victim_d;
      cnt_q    <= cnt_d;
      issued_q <= issued_d;
      pv_q     <= pv_d;
    end
  end

  // result registers, all zero unless a lookup hit
  logic                        res_hit;
  logic [HIT_IDX_W+IDX_W-1:0]  idx_ext;
  logic                        hit_q;
  logic [HIT_IDX_W-1:0]        hidx_q;
  logic [FRAME_W-1:0]          rframe_q;
  logic                        rglob_q;
  logic [PERM_W-1:0]           rperm_q;

  assign res_hit = cmd_i.scan && match && (kind_q == KIND_LOOKUP);
  assign idx_ext = {{HIT_IDX_W{1'b0}}, ridx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (res_hit) begin
        hit_q    <= 1'b1;
        hidx_q   <= idx_ext[HIT_IDX_W-1:0];
        rframe_q <= rdata_q[FRM_LSB +: FRAME_W];
        rglob_q  <= glob_q[ridx_q];
        rperm_q  <= rdata_q[PERM_W-1:0];
      end else begin
        hit_q    <= 1'b0;
        hidx_q   <= '0;
        rframe_q <= '0;
        rglob_q  <= 1'b0;
        rperm_q  <= '0;
      end
    end
  end

  assign hit_o            = hit_q;
  assign hit_index_o      = hidx_q;
  assign page_frame_o     = rframe_q;
  assign global_page_o    = rglob_q;
  assign read_modes_o     = rperm_q[MODES_W-1:0];
  assign write_modes_o    = rperm_q[MODES_W +: MODES_W];
  assign fault_on_read_o  = rperm_q[2*MODES_W];
  assign fault_on_write_o = rperm_q[2*MODES_W+1];

`ifndef NO_ASSERTIONS
  a_flush_all_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (kind_q == KIND_FLUSH_ALL) |=> valid_q == '0 && victim_q == '0)
    else $error("flush all left entries valid");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (kind_q == KIND_INSERT) |=> $countones(valid_q) >= 1)
    else $error("insert left no valid entry");

  a_no_hit_off_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (kind_q != KIND_LOOKUP) |=> !hit_q)
    else $error("hit reported for a request other than lookup");
`endif

endmodule

@@ sv/asid_tagged_tlb_round_robin.sv @@
// lookup and flush-address walk the entries one per cycle through the entry ram
// a lookup stops at its first hit; flush-address and a lookup miss walk every entry
// insert and both flush-all kinds go from accept to the update state, which loads the strobe register
// a new beat is taken in the strobe cycle; the receiver cannot stall
// reset clears all valid bits and the victim pointer at once, no clearing pass
// ----------------------------------------------------------------------------
// asid_tagged_tlb_round_robin
// Fully associative translation buffer with address space tags and
// round-robin replacement.
// ----------------------------------------------------------------------------
module asid_tagged_tlb_round_robin
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES    = DEF_ENTRIES,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [VA_W-1:0]      virtual_address_i,
  input  logic [ASN_W-1:0]     asn_i,
  input  logic [FRAME_W-1:0]   new_page_frame_i,
  input  logic                 new_global_i,
  input  logic [MODES_W-1:0]   new_read_modes_i,
  input  logic [MODES_W-1:0]   new_write_modes_i,
  input  logic                 new_fault_on_read_i,
  input  logic                 new_fault_on_write_i,
  output logic                 valid_o,
  output logic                 hit_o,
  output logic [HIT_IDX_W-1:0] hit_index_o,
  output logic [FRAME_W-1:0]   page_frame_o,
  output logic                 global_page_o,
  output logic [MODES_W-1:0]   read_modes_o,
  output logic [MODES_W-1:0]   write_modes_o,
  output logic                 fault_on_read_o,
  output logic                 fault_on_write_o
);

  cmd_t    cmd;
  status_t status;

  atlb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .valid_o  (valid_o)
  );

  atlb_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .kind_i               (kind_i),
    .virtual_address_i    (virtual_address_i),
    .asn_i                (asn_i),
    .new_page_frame_i     (new_page_frame_i),
    .new_global_i         (new_global_i),
    .new_read_modes_i     (new_read_modes_i),
    .new_write_modes_i    (new_write_modes_i),
    .new_fault_on_read_i  (new_fault_on_read_i),
    .new_fault_on_write_i (new_fault_on_write_i),
    .hit_o                (hit_o),
    .hit_index_o          (hit_index_o),
    .page_frame_o         (page_frame_o),
    .global_page_o        (global_page_o),
    .read_modes_o         (read_modes_o),
    .write_modes_o        (write_modes_o),
    .fault_on_read_o      (fault_on_read_o),
    .fault_on_write_o     (fault_on_write_o)
  );

endmodule
